// File: hw/rtl/vtek_pkg.sv
// Shared types, key codes and sequence lookup for the escape key decoder.
package vtek_pkg;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_B1   = 2'd1,
		PH_B2   = 2'd2,
		PH_B3   = 2'd3
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [8:0] code;
	} key_res_t;

	localparam logic [0:0] REQ_BYTE = 1'b0;
	localparam logic [0:0] REQ_TICK = 1'b1;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_CSI   = 8'h5B; // '['
	localparam logic [7:0] CH_SS3   = 8'h4F; // 'O'
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] WAIT_MAX      = 16'hFFFF;

	localparam logic [8:0] KEY_ESC   = 9'd256;
	localparam logic [8:0] KEY_UP    = 9'd257;
	localparam logic [8:0] KEY_DOWN  = 9'd258;
	localparam logic [8:0] KEY_RIGHT = 9'd259;
	localparam logic [8:0] KEY_LEFT  = 9'd260;
	localparam logic [8:0] KEY_POS1  = 9'd261;
	localparam logic [8:0] KEY_END   = 9'd262;
	localparam logic [8:0] KEY_INS   = 9'd263;
	localparam logic [8:0] KEY_DEL   = 9'd264;
	localparam logic [8:0] KEY_PGUP  = 9'd265;
	localparam logic [8:0] KEY_PGDN  = 9'd266;

	// Match a collected sequence; unknown sequences give ESC.
	function automatic logic [8:0] seq_lookup(input logic len3, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2);
		logic [8:0] code;
		code = KEY_ESC;
		if (!len3) begin
			if (b0 == CH_CSI) begin
				case (b1)
					8'h41: code = KEY_UP;    // 'A'
					8'h42: code = KEY_DOWN;  // 'B'
					8'h43: code = KEY_RIGHT; // 'C'
					8'h44: code = KEY_LEFT;  // 'D'
					8'h48: code = KEY_POS1;  // 'H'
					8'h46: code = KEY_END;   // 'F'
					default: code = KEY_ESC;
				endcase
			end else if (b0 == CH_SS3) begin
				case (b1)
					8'h48: code = KEY_POS1;
					8'h46: code = KEY_END;
					default: code = KEY_ESC;
				endcase
			end
		end else if (b0 == CH_CSI && b2 == CH_TILDE) begin
			case (b1)
				8'h31: code = KEY_POS1;
				8'h32: code = KEY_INS;
				8'h33: code = KEY_DEL;
				8'h34: code = KEY_END;
				8'h35: code = KEY_PGUP;
				8'h36: code = KEY_PGDN;
				8'h37: code = KEY_POS1;
				8'h38: code = KEY_END;
				default: code = KEY_ESC;
			endcase
		end
		return code;
	endfunction

endpackage

// File: hw/rtl/vtek_fsm.sv
// Sequence state machine: phase, collected bytes, timeout counter and result decode.
module vtek_fsm import vtek_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	input  logic [15:0] timeout_ticks,
	output phase_t      phase,
	output key_res_t    res
);

	phase_t      phase_q, phase_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  second_q, second_d;
	logic [15:0] wait_q, wait_d;
	logic [15:0] wait_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			first_q  <= '0;
			second_q <= '0;
			wait_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			first_q  <= first_d;
			second_q <= second_d;
			wait_q   <= wait_d;
		end
	end

	assign wait_inc = (wait_q != WAIT_MAX) ? wait_q + 16'd1 : wait_q;

	always_comb begin
		phase_d   = phase_q;
		first_d   = first_q;
		second_d  = second_q;
		wait_d    = wait_q;
		res.valid = 1'b0;
		res.code  = '0;
		if (step_en) begin
			if (req_type == REQ_TICK) begin
				if (phase_q != PH_IDLE) begin
					if (wait_inc >= timeout_ticks) begin
						phase_d   = PH_IDLE;
						wait_d    = '0;
						res.valid = 1'b1;
						res.code  = KEY_ESC;
					end else begin
						wait_d = wait_inc;
					end
				end
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (data_byte == CH_ESC) begin
							phase_d = PH_B1;
							wait_d  = '0;
						end else begin
							res.valid = 1'b1;
							res.code  = {1'b0, data_byte};
						end
					end
					PH_B1: begin
						first_d = data_byte;
						phase_d = PH_B2;
						wait_d  = '0;
					end
					PH_B2: begin
						second_d = data_byte;
						wait_d   = '0;
						if (first_q == CH_CSI && data_byte inside {[CH_ZERO:CH_NINE]}) begin
							phase_d = PH_B3;
						end else begin
							phase_d   = PH_IDLE;
							res.valid = 1'b1;
							res.code  = seq_lookup(1'b0, first_q, data_byte, 8'h00);
						end
					end
					PH_B3: begin
						phase_d   = PH_IDLE;
						wait_d    = '0;
						res.valid = 1'b1;
						res.code  = seq_lookup(1'b1, first_q, second_q, data_byte);
					end
					default: begin
						phase_d = PH_IDLE;
						wait_d  = '0;
					end
				endcase
			end
		end
	end

	assign phase = phase_q;

endmodule

// File: hw/rtl/vt_escape_key_decoder_top.sv
// Top level of the escape key decoder: input register, sequence FSM, result register.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   req_type, data_byte
//   out      source     out_valid / out_stall keycode
//   cfg      sink       cfg_wen               cfg_wdata (timeout_ticks)
//
// One word per cycle sustained while out_stall does not hold the result. An accepted word is held
// in the input register; the FSM decodes it in a single pass and writes the result register.
// A stalled result holds the result register; the word in the input register waits and
// in_stall rises.
// Reset clears all control state and sets the timeout to 100 ticks.
module vt_escape_key_decoder_top import vtek_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [8:0]  keycode,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata
);

	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  data_byte_s1;
	logic        res_valid_q;
	logic [8:0]  keycode_q;
	logic [15:0] timeout_q;
	logic        advance;
	logic        accept_in;
	phase_t      phase;
	key_res_t    res;

	assign advance   = valid_s1 && (!res_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_wen) begin
			timeout_q <= cfg_wdata;
		end
	end

	// hold the incoming word until the decoder takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_type_s1  <= req_type;
			data_byte_s1 <= data_byte;
		end
	end

	vtek_fsm u_fsm (
		.clk           (clk),
		.arst_n        (arst_n),
		.step_en       (advance),
		.req_type      (req_type_s1),
		.data_byte     (data_byte_s1),
		.timeout_ticks (timeout_q),
		.phase         (phase),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= res.valid;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			keycode_q <= res.code;
		end
	end

	assign out_valid = res_valid_q;
	assign keycode   = keycode_q;

`ifndef NO_ASSERTIONS
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res_valid_q && out_stall)
		else $error("input stalled without a blocked word");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> keycode <= KEY_PGDN)
		else $error("key code out of range");

	a_idle_tick_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_type_s1 == REQ_TICK && phase == PH_IDLE |=> !out_valid)
		else $error("tick in idle produced a key");
`endif

endmodule
